// ----- src/pft_pkg.sv -----
// Shared constants, codes and table port types for the page translation block.
package pft_pkg;

  localparam int OFFSET_BITS = 8;
  localparam int PAGE_COUNT  = 8;
  localparam int FRAME_COUNT = 4;

  localparam int ADDR_W     = 16;
  localparam int PAGE_NUM_W = ADDR_W - OFFSET_BITS;
  localparam int PAGE_BITS  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int FRAME_BITS = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int FIU_W      = FRAME_BITS + 1;

  // result field widths
  localparam int PHYS_W   = 10;
  localparam int STATUS_W = 2;
  localparam int FRAME_W  = 2;
  localparam int EVICT_W  = 3;
  localparam int COUNT_W  = 16;

  localparam int OUT_FIELDS_W = PHYS_W + STATUS_W + FRAME_W + EVICT_W + 2 * COUNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // bit positions inside out_tdata
  localparam int STATUS_LSB = PHYS_W;
  localparam int FRAME_LSB  = STATUS_LSB + STATUS_W;
  localparam int EVICT_LSB  = FRAME_LSB + FRAME_W;
  localparam int HIT_LSB    = EVICT_LSB + EVICT_W;
  localparam int FAULT_LSB  = HIT_LSB + COUNT_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 2'd0,
    ST_FREE    = 2'd1,
    ST_REPLACE = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // requests to the translation tables
  typedef struct packed {
    logic                  rd_en;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [FRAME_BITS-1:0] rd_frame;
    logic                  map_we;
    logic [PAGE_BITS-1:0]  map_page;
    logic [FRAME_BITS-1:0] map_frame;
    logic                  own_we;
    logic [FRAME_BITS-1:0] own_frame;
    logic [PAGE_BITS-1:0]  own_page;
    logic                  clr_en;
    logic [PAGE_BITS-1:0]  clr_page;
  } tbl_req_t;

  // registered read data from the tables
  typedef struct packed {
    logic                  map_valid;
    logic [FRAME_BITS-1:0] map_frame;
    logic [PAGE_BITS-1:0]  own_page;
  } tbl_rsp_t;

endpackage

// ----- src/pft_tables.sv -----
// Page map and frame owner memories with per-page present bits.
module pft_tables (
  input  logic              clk,
  input  logic              rst_n,
  input  pft_pkg::tbl_req_t req,
  output pft_pkg::tbl_rsp_t rsp
);
  import pft_pkg::*;

  logic [FRAME_BITS-1:0] map_mem [PAGE_COUNT];
  logic [PAGE_BITS-1:0]  own_mem [FRAME_COUNT];
  logic [PAGE_COUNT-1:0] present_r;
  logic [PAGE_COUNT-1:0] present_nxt;
  tbl_rsp_t              rsp_r;

  always_comb begin
    present_nxt = present_r;
    if (req.clr_en) begin
      present_nxt[req.clr_page] = 1'b0;
    end
    if (req.map_we) begin
      present_nxt[req.map_page] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else begin
      present_r <= present_nxt;
    end
  end

  // memories: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (req.map_we) begin
      map_mem[req.map_page] <= req.map_frame;
    end
    if (req.own_we) begin
      own_mem[req.own_frame] <= req.own_page;
    end
    if (req.rd_en) begin
      rsp_r.map_valid <= present_r[req.rd_page];
      rsp_r.map_frame <= map_mem[req.rd_page];
      rsp_r.own_page  <= own_mem[req.rd_frame];
    end
  end

  assign rsp = rsp_r;

endmodule

// ----- src/page_translate_fifo_replace.sv -----
// Paged address translation with FIFO frame replacement.
// An accepted word is registered with its table read data; the lookup then commits
// into the result register once it is free, and a stalled result word holds the lookup.
// Only one word is in lookup at a time: a new word is taken after the last commits;
// the tables are read when a word is accepted and written back when it commits.
// Reset (rst_n low, synchronous) clears all page present bits, the frame fill
// count, the replace pointer and both counters at once; no clearing pass.
module page_translate_fifo_replace (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pft_pkg::ADDR_W-1:0]         in_tdata,   // [15:0] logical_address
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [9:0] physical_address, [11:10] status, [13:12] frame_used,
  // [16:14] evicted_page, [32:17] hit_total, [48:33] fault_total, [55:49] zero
  output logic [pft_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import pft_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_t;

  localparam logic [PAGE_NUM_W:0] PAGE_LIMIT  = (PAGE_NUM_W + 1)'(PAGE_COUNT);
  localparam logic [FIU_W-1:0]    FRAME_FULL  = FIU_W'(FRAME_COUNT);
  localparam logic [FRAME_BITS-1:0] PTR_LAST  = FRAME_BITS'(FRAME_COUNT - 1);
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;

  state_t                 state_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [FIU_W-1:0]       fiu_r, fiu_nxt;
  logic [FRAME_BITS-1:0]  ptr_r, ptr_nxt;
  logic [COUNT_W-1:0]     hit_r, hit_nxt;
  logic [COUNT_W-1:0]     fault_r, fault_nxt;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  tbl_req_t               req;
  tbl_rsp_t               rsp;

  logic                   accept;
  logic                   commit;
  logic [PAGE_NUM_W-1:0]  page_num;
  logic [OFFSET_BITS-1:0] offset;
  logic                   page_ok;
  status_t                status;
  logic [FRAME_BITS-1:0]  frame;
  logic [PAGE_BITS-1:0]   evicted;
  logic [PHYS_W+FRAME_BITS+OFFSET_BITS-1:0] phys_ext;
  logic [FRAME_W+FRAME_BITS-1:0]            frame_ext;
  logic [EVICT_W+PAGE_BITS-1:0]             evict_ext;
  logic [PHYS_W-1:0]      phys;

  pft_tables u_tables (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign accept = in_tvalid && in_tready;
  assign commit = (state_r == S_LOOK) && (!out_valid_r || out_tready);

  assign page_num = addr_r[ADDR_W-1:OFFSET_BITS];
  assign offset   = addr_r[OFFSET_BITS-1:0];
  assign page_ok  = {1'b0, page_num} < PAGE_LIMIT;

  always_comb begin
    status    = ST_INVALID;
    frame     = '0;
    evicted   = '0;
    fiu_nxt   = fiu_r;
    ptr_nxt   = ptr_r;
    hit_nxt   = hit_r;
    fault_nxt = fault_r;
    if (page_ok) begin
      if (rsp.map_valid) begin
        status  = ST_HIT;
        frame   = rsp.map_frame;
        hit_nxt = (hit_r == COUNT_MAX) ? hit_r : hit_r + 1'b1;
      end else begin
        fault_nxt = (fault_r == COUNT_MAX) ? fault_r : fault_r + 1'b1;
        if (fiu_r != FRAME_FULL) begin
          status  = ST_FREE;
          frame   = fiu_r[FRAME_BITS-1:0];
          fiu_nxt = fiu_r + 1'b1;
        end else begin
          // every frame owned: evict the page held by the FIFO pointer's frame
          status  = ST_REPLACE;
          frame   = ptr_r;
          evicted = rsp.own_page;
          ptr_nxt = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    req           = '0;
    req.rd_en     = accept;
    req.rd_page   = in_tdata[OFFSET_BITS +: PAGE_BITS];
    req.rd_frame  = ptr_r;
    req.map_page  = page_num[PAGE_BITS-1:0];
    req.map_frame = frame;
    req.own_frame = frame;
    req.own_page  = page_num[PAGE_BITS-1:0];
    req.clr_page  = evicted;
    if (commit && page_ok && !rsp.map_valid) begin
      req.map_we = 1'b1;
      req.own_we = 1'b1;
      req.clr_en = (status == ST_REPLACE);
    end
  end

  always_comb begin
    phys_ext  = {PHYS_W'(0), frame, offset};
    frame_ext = {FRAME_W'(0), frame};
    evict_ext = {EVICT_W'(0), evicted};
    phys      = (status == ST_INVALID) ? '0 : phys_ext[PHYS_W-1:0];
    out_data_nxt = '0;
    out_data_nxt[PHYS_W-1:0]                 = phys;
    out_data_nxt[STATUS_LSB +: STATUS_W]     = status;
    out_data_nxt[FRAME_LSB +: FRAME_W]       = frame_ext[FRAME_W-1:0];
    out_data_nxt[EVICT_LSB +: EVICT_W]       = evict_ext[EVICT_W-1:0];
    out_data_nxt[HIT_LSB +: COUNT_W]         = hit_nxt;
    out_data_nxt[FAULT_LSB +: COUNT_W]       = fault_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fiu_r       <= '0;
      ptr_r       <= '0;
      hit_r       <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            addr_r  <= in_tdata;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (commit) begin
            fiu_r       <= fiu_nxt;
            ptr_r       <= ptr_nxt;
            hit_r       <= hit_nxt;
            fault_r     <= fault_nxt;
            out_data_r  <= out_data_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- src/pft_checker.sv -----
// Port-level checks for the page translation block, bound to the top level.
module pft_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [pft_pkg::ADDR_W-1:0]     in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pft_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pft_pkg::*;

  logic [STATUS_W-1:0] st;
  assign st = out_tdata[STATUS_LSB +: STATUS_W];

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in flight");

  // invalid page reports zero address, frame and evicted page
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_INVALID |->
      out_tdata[PHYS_W-1:0] == '0 && out_tdata[FRAME_LSB +: FRAME_W] == '0 &&
      out_tdata[EVICT_LSB +: EVICT_W] == '0)
    else $error("invalid page result carries nonzero fields");

  // only a replacement names an evicted page
  a_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ST_HIT || st == ST_FREE) |->
      out_tdata[EVICT_LSB +: EVICT_W] == '0)
    else $error("evicted page set without replacement");

endmodule

bind page_translate_fifo_replace pft_checker u_pft_checker (.*);

// ----- verif/pft_xlat_checker.sv -----
// Translation checker: predicts each accepted address and compares the returned words.
`timescale 1ns / 100ps

module pft_xlat_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [pft_pkg::ADDR_W-1:0]     in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [pft_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             err_count,
  output int                             xlat_pending,
  output int                             n_hit,
  output int                             n_fill,
  output int                             n_replace,
  output int                             n_invalid
);
  import pft_pkg::*;

  typedef struct packed {
    logic [PHYS_W-1:0]  phys;
    status_t            status;
    logic [FRAME_W-1:0] frame;
    logic [EVICT_W-1:0] evicted;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] faults;
  } xlat_result_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    xlat_result_t      res;
  } xlat_expect_t;

  // shadow of the translation tables
  logic                  map_valid [PAGE_COUNT];
  logic [FRAME_BITS-1:0] map_frame [PAGE_COUNT];
  logic                  own_valid [FRAME_COUNT];
  logic [PAGE_BITS-1:0]  own_page  [FRAME_COUNT];
  int                    frames_filled;
  int                    victim_ptr;
  logic [COUNT_W-1:0]    hit_tally;
  logic [COUNT_W-1:0]    fault_tally;

  xlat_expect_t pending_xlat[$];

  initial begin
    err_count    = 0;
    xlat_pending = 0;
    n_hit        = 0;
    n_fill       = 0;
    n_replace    = 0;
    n_invalid    = 0;
  end

  function automatic xlat_result_t translate_addr(input logic [ADDR_W-1:0] addr);
    xlat_result_t r;
    int           page;
    int           offset;
    int           frame;
    page   = int'(addr[ADDR_W-1:OFFSET_BITS]);
    offset = int'(addr[OFFSET_BITS-1:0]);
    frame  = 0;
    r      = '0;
    if (page >= PAGE_COUNT) begin
      r.status = ST_INVALID;
    end else if (map_valid[page]) begin
      r.status = ST_HIT;
      frame    = int'(map_frame[page]);
      if (hit_tally != '1) hit_tally++;
    end else begin
      if (fault_tally != '1) fault_tally++;
      if (frames_filled < FRAME_COUNT) begin
        r.status = ST_FREE;
        frame    = frames_filled;
        frames_filled++;
      end else begin
        r.status = ST_REPLACE;
        frame    = victim_ptr;
        // a free frame under the pointer evicts nothing
        if (own_valid[frame]) begin
          r.evicted = EVICT_W'(own_page[frame]);
          map_valid[own_page[frame]] = 1'b0;
          map_frame[own_page[frame]] = '0;
        end
        victim_ptr = (frame + 1) % FRAME_COUNT;
      end
      own_valid[frame] = 1'b1;
      own_page[frame]  = PAGE_BITS'(page);
      map_valid[page]  = 1'b1;
      map_frame[page]  = FRAME_BITS'(frame);
    end
    if (r.status != ST_INVALID) begin
      r.phys  = PHYS_W'(frame * (1 << OFFSET_BITS) + offset);
      r.frame = FRAME_W'(frame);
    end
    r.hits   = hit_tally;
    r.faults = fault_tally;
    return r;
  endfunction

  always @(posedge clk) begin
    xlat_expect_t e;
    xlat_result_t act;
    if (!rst_n) begin
      for (int p = 0; p < PAGE_COUNT; p++) begin
        map_valid[p] = 1'b0;
        map_frame[p] = '0;
      end
      for (int f = 0; f < FRAME_COUNT; f++) begin
        own_valid[f] = 1'b0;
        own_page[f]  = '0;
      end
      frames_filled = 0;
      victim_ptr    = 0;
      hit_tally     = '0;
      fault_tally   = '0;
      pending_xlat.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        act.phys    = out_tdata[PHYS_W-1:0];
        act.status  = status_t'(out_tdata[STATUS_LSB +: STATUS_W]);
        act.frame   = out_tdata[FRAME_LSB +: FRAME_W];
        act.evicted = out_tdata[EVICT_LSB +: EVICT_W];
        act.hits    = out_tdata[HIT_LSB +: COUNT_W];
        act.faults  = out_tdata[FAULT_LSB +: COUNT_W];
        if (pending_xlat.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("[%0t] unexpected result word %h", $realtime, out_tdata);
        end else begin
          e = pending_xlat.pop_front();
          if (act.phys !== e.res.phys || act.status !== e.res.status ||
              act.frame !== e.res.frame || act.evicted !== e.res.evicted ||
              act.hits !== e.res.hits || act.faults !== e.res.faults) begin
            err_count++;
            if (err_count <= 10) begin
              $display("[%0t] mismatch for address %h", $realtime, e.addr);
              $display("  exp phys %0d status %0d frame %0d evict %0d hits %0d faults %0d",
                       e.res.phys, e.res.status, e.res.frame, e.res.evicted,
                       e.res.hits, e.res.faults);
              $display("  got phys %0d status %0d frame %0d evict %0d hits %0d faults %0d",
                       act.phys, act.status, act.frame, act.evicted,
                       act.hits, act.faults);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        e.addr = in_tdata;
        e.res  = translate_addr(in_tdata);
        case (e.res.status)
          ST_HIT:     n_hit++;
          ST_FREE:    n_fill++;
          ST_REPLACE: n_replace++;
          default:    n_invalid++;
        endcase
        pending_xlat.push_back(e);
      end
    end
    xlat_pending = pending_xlat.size();
  end

endmodule

// ----- verif/tb_page_translate_fifo_replace.sv -----
// Top of the page translation testbench: clock, reset, address stimulus and verdict.
`timescale 1ns / 100ps

module tb_page_translate_fifo_replace;
  import pft_pkg::*;

  localparam int CYCLE_LIMIT = 60_000;
  localparam int PHASE_WORDS = 650;
  localparam int DIR_WORDS   = 22;

  // extremes, fill, replacement with pointer wrap, invalid pages
  localparam logic [ADDR_W-1:0] DIRECTED [DIR_WORDS] = '{
    16'h0000, 16'h00FF, 16'h01AB, 16'h0234, 16'h0377, 16'h0400, 16'h0000,
    16'h0480, 16'h07FF, 16'h0800, 16'hFFFF, 16'hFF00, 16'h0500, 16'h0600,
    16'h0101, 16'h06FE, 16'h0200, 16'h0300, 16'h0700, 16'h0155, 16'h08FF,
    16'h07AA
  };

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [ADDR_W-1:0]     in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_len  = 0;
  int work_set  = PAGE_COUNT;
  int cycle_cnt = 0;

  int err_count;
  int xlat_pending;
  int n_hit;
  int n_fill;
  int n_replace;
  int n_invalid;

  page_translate_fifo_replace u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pft_xlat_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .err_count    (err_count),
    .xlat_pending (xlat_pending),
    .n_hit        (n_hit),
    .n_fill       (n_fill),
    .n_replace    (n_replace),
    .n_invalid    (n_invalid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, xlat_pending);
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random backpressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_len > 0) begin
      out_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_word(input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // mostly pages inside a shifting working set, some fully random addresses
  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [ADDR_W-1:0] a;
    int                pick;
    if ($urandom_range(49) == 0) begin
      case ($urandom_range(2))
        0:       work_set = 3;
        1:       work_set = FRAME_COUNT + 1;
        default: work_set = PAGE_COUNT;
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 8)
      a = ADDR_W'($urandom);
    else
      a = {PAGE_NUM_W'($urandom_range(work_set - 1)), OFFSET_BITS'($urandom)};
    return a;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 6;
    recv_idle = 60;
    for (int i = 0; i < DIR_WORDS; i++) send_word(DIRECTED[i]);
    for (int i = 0; i < PHASE_WORDS; i++) send_word(rand_addr());

    send_idle = 60;
    recv_idle = 6;
    for (int i = 0; i < PHASE_WORDS; i++) send_word(rand_addr());

    send_idle = 0;
    recv_idle = 0;
    // sink stalls long enough to back up into the input
    hold_len = 400;
    for (int i = 0; i < PHASE_WORDS; i++) send_word(rand_addr());
    in_tvalid <= 1'b0;

    while (xlat_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("translated %0d addresses: %0d hits, %0d free-frame fills, %0d replacements,",
             n_hit + n_fill + n_replace + n_invalid, n_hit, n_fill, n_replace);
    $display("%0d out-of-range pages; both-side idling and a long sink stall", n_invalid);
    if (err_count == 0 && xlat_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors", err_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
